>>> hw/rtl/tcts_pkg.sv
// ----------------------------------------------------------------------------
// tcts_pkg: shared types and constants of the two-channel timed switch
// Request kinds, field widths, configuration indexes and the per-channel
// request bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcts_pkg;

	// Width of the on-time fields on the ports and of the reported countdown.
	localparam int TIME_W = 16;

	// Default width of the countdown registers.
	localparam int TIMER_BITS_DEF = 16;

	// Configuration port.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FOLLOW_1 = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FOLLOW_2 = 1'd1;

	typedef enum logic [1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_COIL   = 2'd1,
		REQ_TIMER  = 2'd2,
		REQ_TICK   = 2'd3
	} req_type_t;

	// What one channel needs to know about an accepted request.
	typedef struct packed {
		req_type_t         kind;
		logic              level;
		logic              coil;
		logic [TIME_W-1:0] timer_value;
	} chan_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/tcts_req_if.sv
// ----------------------------------------------------------------------------
// tcts_req_if: request channel of the two-channel timed switch
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcts_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  req_type;
	logic                        input_level_1;
	logic                        input_level_2;
	logic                        coil_value_1;
	logic                        coil_value_2;
	logic [tcts_pkg::TIME_W-1:0] timer_value_1;
	logic [tcts_pkg::TIME_W-1:0] timer_value_2;

	modport source (
		output valid, req_type, input_level_1, input_level_2,
		       coil_value_1, coil_value_2, timer_value_1, timer_value_2,
		input  ready
	);

	modport sink (
		input  valid, req_type, input_level_1, input_level_2,
		       coil_value_1, coil_value_2, timer_value_1, timer_value_2,
		output ready
	);
endinterface

`default_nettype wire

>>> hw/rtl/tcts_res_if.sv
// ----------------------------------------------------------------------------
// tcts_res_if: result channel of the two-channel timed switch
// Valid/ready channel carrying both output levels and both countdowns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcts_res_if;
	logic                        valid;
	logic                        ready;
	logic                        output_1;
	logic                        output_2;
	logic [tcts_pkg::TIME_W-1:0] remaining_1;
	logic [tcts_pkg::TIME_W-1:0] remaining_2;

	modport source (
		output valid, output_1, output_2, remaining_1, remaining_2,
		input  ready
	);

	modport sink (
		input  valid, output_1, output_2, remaining_1, remaining_2,
		output ready
	);
endinterface

`default_nettype wire

>>> hw/rtl/tcts_channel.sv
// ----------------------------------------------------------------------------
// tcts_channel: state and update logic of one switch channel
// Holds the latched input level, the output level and the auto-off
// countdown, and applies one request to them per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcts_channel #(
	parameter int TIMER_BITS = tcts_pkg::TIMER_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire tcts_pkg::chan_req_t     req,
	input  wire logic                    follow_enable,
	output logic                         output_state,
	output logic [TIMER_BITS-1:0]        countdown
);

	// Compare width wide enough for both the on-time field and the counter.
	localparam int CMP_W = (TIMER_BITS > tcts_pkg::TIME_W) ? TIMER_BITS : tcts_pkg::TIME_W;
	localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

	logic                  latched_level_q;
	logic                  output_state_q;
	logic [TIMER_BITS-1:0] countdown_q;

	logic                  latched_level_nxt;
	logic                  output_state_nxt;
	logic [TIMER_BITS-1:0] countdown_nxt;
	logic [TIMER_BITS-1:0] clamped;
	logic [TIMER_BITS-1:0] count_dec;
	logic [CMP_W-1:0]      time_wide;

	// An on-time above what the counter holds saturates to its largest count.
	always_comb begin
		time_wide = CMP_W'(req.timer_value);
		if (time_wide > CMP_W'(CNT_MAX)) begin
			clamped = CNT_MAX;
		end else begin
			clamped = TIMER_BITS'(time_wide);
		end
	end

	assign count_dec = countdown_q - TIMER_BITS'(1);

	always_comb begin
		latched_level_nxt = latched_level_q;
		output_state_nxt  = output_state_q;
		countdown_nxt     = countdown_q;
		case (req.kind)
			tcts_pkg::REQ_SAMPLE: begin
				if (req.level != latched_level_q) begin
					latched_level_nxt = req.level;
					countdown_nxt     = '0;
					if (follow_enable) begin
						output_state_nxt = req.level;
					end
				end
			end
			tcts_pkg::REQ_COIL: begin
				if (req.coil != output_state_q) begin
					output_state_nxt = req.coil;
					countdown_nxt    = req.coil ? clamped : '0;
				end
			end
			tcts_pkg::REQ_TIMER: begin
				if (output_state_q && (clamped != '0)) begin
					countdown_nxt = clamped;
				end
			end
			default: begin
				if (countdown_q != '0) begin
					countdown_nxt = count_dec;
					if (count_dec == '0) begin
						output_state_nxt = 1'b0;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_level_q <= 1'b0;
			output_state_q  <= 1'b0;
			countdown_q     <= '0;
		end else if (accept) begin
			latched_level_q <= latched_level_nxt;
			output_state_q  <= output_state_nxt;
			countdown_q     <= countdown_nxt;
		end
	end

	assign output_state = output_state_q;
	assign countdown    = countdown_q;

endmodule

`default_nettype wire

>>> hw/rtl/two_channel_timed_switch.sv
// ----------------------------------------------------------------------------
// two_channel_timed_switch: two output channels with auto-off timers
//
// Requests arrive on the valid/ready channel req: an input sample, a coil
// write, a timer write or a one-second tick, each acting on both channels.
// Every accepted request yields exactly one result on res: both output
// levels and both remaining countdowns after the request.
// The result is valid in the cycle after the transfer. Throughput is one
// request per cycle while res is not stalled; the channel state registers
// double as the result register, so req is ready whenever the result slot
// is empty or is being taken in the same cycle. When the receiver stalls, the
// result holds and req stays ready low. The follow enables are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, which is not enforced. Reset clears outputs, countdowns
// and latched levels, empties the result slot and sets both follow enables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_channel_timed_switch #(
	parameter int TIMER_BITS = tcts_pkg::TIMER_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	tcts_req_if.sink                              req,
	tcts_res_if.source                            res,
	input  wire logic                             cfg_we,
	input  wire logic [tcts_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tcts_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                  follow_enable_1_q;
	logic                  follow_enable_2_q;
	logic                  res_valid_q;
	logic                  accept;
	tcts_pkg::req_type_t   kind;
	tcts_pkg::chan_req_t   req_1;
	tcts_pkg::chan_req_t   req_2;
	logic                  out_1;
	logic                  out_2;
	logic [TIMER_BITS-1:0] count_1;
	logic [TIMER_BITS-1:0] count_2;

	assign req.ready = !res_valid_q || res.ready;
	assign accept    = req.valid && req.ready;
	assign kind      = tcts_pkg::req_type_t'(req.req_type);

	assign req_1 = '{kind: kind, level: req.input_level_1, coil: req.coil_value_1,
	                 timer_value: req.timer_value_1};
	assign req_2 = '{kind: kind, level: req.input_level_2, coil: req.coil_value_2,
	                 timer_value: req.timer_value_2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			follow_enable_1_q <= 1'b1;
			follow_enable_2_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == tcts_pkg::CFG_FOLLOW_1) begin
				follow_enable_1_q <= cfg_data[0];
			end
			if (cfg_index == tcts_pkg::CFG_FOLLOW_2) begin
				follow_enable_2_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	tcts_channel #(
		.TIMER_BITS(TIMER_BITS)
	) u_chan_1 (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req          (req_1),
		.follow_enable(follow_enable_1_q),
		.output_state (out_1),
		.countdown    (count_1)
	);

	tcts_channel #(
		.TIMER_BITS(TIMER_BITS)
	) u_chan_2 (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req          (req_2),
		.follow_enable(follow_enable_2_q),
		.output_state (out_2),
		.countdown    (count_2)
	);

	// The channel state only moves on a transfer, so it is the result itself.
	assign res.valid       = res_valid_q;
	assign res.output_1    = out_1;
	assign res.output_2    = out_2;
	assign res.remaining_1 = tcts_pkg::TIME_W'(count_1);
	assign res.remaining_2 = tcts_pkg::TIME_W'(count_2);

endmodule

`default_nettype wire
